[rtl/record_exchange_sort_by_key_assert.svh]
// ----------------------------------------------------------------------------
// record_exchange_sort_by_key_assert
// Assertion macros used by the checker file of the record sorter.
// ----------------------------------------------------------------------------
`ifndef RECORD_EXCHANGE_SORT_BY_KEY_ASSERT_SVH
`define RECORD_EXCHANGE_SORT_BY_KEY_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define RSK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define RSK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rsk_pkg.sv]
// ----------------------------------------------------------------------------
// rsk_pkg
// Shared types and constants of the record exchange sorter: the record
// layout, the sequencer states and the control bundle to the datapath.
// ----------------------------------------------------------------------------
package rsk_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    logic [15:0] id;
    logic [6:0]  age;
    logic [7:0]  sex_char;
    logic [3:0]  grade_one;
    logic [3:0]  grade_two;
    logic [3:0]  grade_three;
    logic [9:0]  average_x100;
  } record_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LATCH,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             store_in;
    logic             latch;
    logic             scan;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
  } ctrl_t;

endpackage

[rtl/rsk_store.sv]
// ----------------------------------------------------------------------------
// rsk_store
// Record memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsk_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [rsk_pkg::IDX_W-1:0] wr_addr,
  input  rsk_pkg::record_t          wr_data,
  input  logic [rsk_pkg::IDX_W-1:0] rd_addr,
  output rsk_pkg::record_t          rd_data
);
  import rsk_pkg::*;

  record_t mem [MAX_RECORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/rsk_ctrl.sv]
// ----------------------------------------------------------------------------
// rsk_ctrl
// Sequencer of the sorter: counts loaded records, walks the outer and inner
// positions of the exchange procedure and hands out each settled record.
// ----------------------------------------------------------------------------
module rsk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           last_record,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_last,
  output logic           overflow_flag,
  output rsk_pkg::ctrl_t ctrl
);
  import rsk_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] i, i_next;
  logic [CNT_W-1:0] j, j_next;
  logic             dropped, dropped_next;
  logic [CNT_W-1:0] i_inc, j_inc;
  logic             in_xfer, out_xfer, has_room;

  assign i_inc    = i + 1'b1;
  assign j_inc    = j + 1'b1;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign has_room = count < CNT_W'(MAX_RECORDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      i       <= '0;
      j       <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      i       <= i_next;
      j       <= j_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer && last_record) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_LATCH;
      ST_LATCH: state_next = (i_inc == count) ? ST_EMIT : ST_SCAN;
      ST_SCAN:  if (j_inc == count) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_xfer) begin
          state_next = (i_inc == count) ? ST_IDLE : ST_FETCH;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Counter updates follow the same walk as the state register.
  always_comb begin
    count_next   = count;
    i_next       = i;
    j_next       = j;
    dropped_next = dropped;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (has_room) begin
            count_next = count + 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
          i_next = '0;
        end
      end
      ST_LATCH: j_next = i_inc;
      ST_SCAN:  j_next = j_inc;
      ST_EMIT: begin
        if (out_xfer) begin
          i_next = i_inc;
          if (i_inc == count) begin
            count_next   = '0;
            dropped_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    ctrl.store_in = 1'b0;
    ctrl.latch    = 1'b0;
    ctrl.scan     = 1'b0;
    ctrl.wr_addr  = count[IDX_W-1:0];
    ctrl.rd_addr  = i[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        ctrl.store_in = in_valid && has_room;
      end
      ST_FETCH: ctrl.rd_addr = i[IDX_W-1:0];
      ST_LATCH: begin
        ctrl.latch   = 1'b1;
        ctrl.rd_addr = i_inc[IDX_W-1:0];
      end
      ST_SCAN: begin
        // Compare position j while the read of position j+1 is under way.
        ctrl.scan    = 1'b1;
        ctrl.wr_addr = j[IDX_W-1:0];
        ctrl.rd_addr = j_inc[IDX_W-1:0];
      end
      ST_EMIT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_last      = (i_inc == count);
  assign overflow_flag = dropped;

endmodule

[rtl/record_exchange_sort_by_key.sv]
// ----------------------------------------------------------------------------
// record_exchange_sort_by_key
// Collects records, sorts them ascending by id with an exchange sort on a
// single compare unit, and streams them out in order.
// ----------------------------------------------------------------------------
// A record that does not close a set is written into the store as it is
// taken. A record with last_record set starts the sort of the n stored
// records; for each position i the block reads the record into a holding
// register through the fetch and latch states and then compares it against
// every later position, one per cycle, swapping through the store's single
// write port. The record at position i is then final and is offered at the
// output until it is transferred. No new record is taken until the last
// sorted record has been transferred. Records beyond the capacity of 32 are
// dropped and every result of that set shows overflow_flag.
module record_exchange_sort_by_key (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] record_id,
  input  logic [6:0]  age,
  input  logic [7:0]  sex_char,
  input  logic [3:0]  grade_one,
  input  logic [3:0]  grade_two,
  input  logic [3:0]  grade_three,
  input  logic [9:0]  average_x100,
  input  logic        last_record,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_id,
  output logic [6:0]  out_age,
  output logic [7:0]  out_sex_char,
  output logic [3:0]  out_grade_one,
  output logic [3:0]  out_grade_two,
  output logic [3:0]  out_grade_three,
  output logic [9:0]  out_average_x100,
  output logic        out_last,
  output logic        overflow_flag
);
  import rsk_pkg::*;

  ctrl_t   ctrl;
  record_t in_rec, rd_data, hold, wr_data;
  logic    swap, wr_en;

  assign in_rec = '{id: record_id, age: age, sex_char: sex_char,
                    grade_one: grade_one, grade_two: grade_two,
                    grade_three: grade_three, average_x100: average_x100};

  // The held record stands for position i; a strictly smaller later key
  // takes its place and the held record goes back to the later position.
  assign swap    = ctrl.scan && (hold.id > rd_data.id);
  assign wr_en   = ctrl.store_in || swap;
  assign wr_data = ctrl.store_in ? in_rec : hold;

  always_ff @(posedge clk) begin
    if (ctrl.latch || swap) begin
      hold <= rd_data;
    end
  end

  rsk_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .last_record   (last_record),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_last      (out_last),
    .overflow_flag (overflow_flag),
    .ctrl          (ctrl)
  );

  rsk_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ctrl.wr_addr),
    .wr_data (wr_data),
    .rd_addr (ctrl.rd_addr),
    .rd_data (rd_data)
  );

  assign out_id           = hold.id;
  assign out_age          = hold.age;
  assign out_sex_char     = hold.sex_char;
  assign out_grade_one    = hold.grade_one;
  assign out_grade_two    = hold.grade_two;
  assign out_grade_three  = hold.grade_three;
  assign out_average_x100 = hold.average_x100;

endmodule

[rtl/rsk_checker.sv]
// ----------------------------------------------------------------------------
// rsk_checker
// Port-level checks of the record sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "record_exchange_sort_by_key_assert.svh"

module rsk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_record,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_id,
  input logic        out_last
);

  // A stalled result keeps its key.
  `RSK_ASSERT(hold_a, out_valid && out_stall |=> out_valid && $stable(out_id), "key moved")

  // No record is taken while sorted records are being handed out.
  `RSK_ASSERT(emit_blocks_in_a, out_valid |-> in_stall, "input open during output")

  // A closing record starts the sort, so input closes at once.
  `RSK_ASSERT(close_a, in_valid && !in_stall && last_record |=> in_stall, "open after close")

  // The final record of a run ends the output burst.
  `RSK_ASSERT(last_a, out_valid && !out_stall && out_last |=> !out_valid, "output after last")

  // Reset leaves the block with nothing to offer.
  `RSK_ASSERT_ALWAYS(reset_quiet_a, rst |=> !out_valid, "result offered after reset")

endmodule

bind record_exchange_sort_by_key rsk_checker u_rsk_checker (.*);
